>>> rtl/core/tepq_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and helpers for the timed event priority queue.
// Used by tepq_cell, timed_event_priority_queue_core and the bench; depends on nothing.
package tepq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int DEPTH_LOG   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   typedef enum logic [1:0] {
      FUNC_INSERT = 2'd0,
      FUNC_REMOVE = 2'd1,
      FUNC_POP    = 2'd2,
      FUNC_SQUASH = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_MISSING   = 2'd2,
      STATUS_DUPLICATE = 2'd3
   } status_type;

   // Contents of one queue slot.
   typedef struct packed {
      logic [63:0]       tick;
      logic signed [7:0] prio;
      logic [7:0]        id;
      logic              valid;
      logic              squashed;
   } slot_type;

   // Operation broadcast to every cell.
   typedef struct packed {
      logic              eval;
      logic              apply;
      logic              ok;
      func_type          func;
      logic [7:0]        id;
      logic [63:0]       tick;
      logic signed [7:0] prio;
   } cmd_type;

   // Per-cell compare results, registered in the cell.
   typedef struct packed {
      logic match;
      logic after;
   } flag_type;

   // Inclusive prefix OR, built as a log-depth tree.
   function automatic logic [QUEUE_DEPTH-1:0] prefix_or(input logic [QUEUE_DEPTH-1:0] bits);
      logic [QUEUE_DEPTH-1:0] acc;
      acc = bits;
      for (int lvl = 0; lvl < DEPTH_LOG; lvl++) begin
         for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
            if (i >= (1 << lvl)) begin
               acc[i] = acc[i] | acc[i - (1 << lvl)];
            end
         end
      end
      return acc;
   endfunction

endpackage

>>> rtl/core/tepq_cell.sv
`timescale 1ns / 1ps
// One slot of the sorted queue: compares its entry with the broadcast operation
// and takes data from a neighbour on a shift. Depends on tepq_pkg.
module tepq_cell (
   input  logic               clock,
   input  logic               reset,
   input  tepq_pkg::cmd_type  cmd,
   input  logic               pre_match,
   input  logic               left_after,
   input  tepq_pkg::slot_type left_slot,
   input  tepq_pkg::slot_type right_slot,
   output tepq_pkg::slot_type slot_out,
   output tepq_pkg::flag_type flags_out
);

   tepq_pkg::slot_type slot_ff, slot_in;
   tepq_pkg::flag_type flags_ff, flags_in;
   logic               later_key;

   // The new entry goes ahead of any entry with an equal key.
   assign later_key = (slot_ff.tick > cmd.tick) ||
                      ((slot_ff.tick == cmd.tick) &&
                       ($signed(slot_ff.prio) >= $signed(cmd.prio)));

   always_comb begin
      flags_in = flags_ff;
      if (cmd.eval) begin
         flags_in.match = slot_ff.valid && (slot_ff.id == cmd.id);
         flags_in.after = !slot_ff.valid || later_key;
      end
   end

   always_comb begin
      slot_in = slot_ff;
      if (cmd.apply && cmd.ok) begin
         case (cmd.func)
            tepq_pkg::FUNC_INSERT: begin
               if (flags_ff.after) begin
                  if (left_after) begin
                     slot_in = left_slot;
                  end else begin
                     slot_in.tick     = cmd.tick;
                     slot_in.prio     = cmd.prio;
                     slot_in.id       = cmd.id;
                     slot_in.valid    = 1'b1;
                     slot_in.squashed = 1'b0;
                  end
               end
            end
            tepq_pkg::FUNC_REMOVE: begin
               if (pre_match) begin
                  slot_in = right_slot;
               end
            end
            tepq_pkg::FUNC_POP: begin
               slot_in = right_slot;
            end
            tepq_pkg::FUNC_SQUASH: begin
               if (flags_ff.match) begin
                  slot_in.squashed = 1'b1;
               end
            end
            default: begin
               slot_in = slot_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      slot_ff.tick <= slot_in.tick;
      slot_ff.prio <= slot_in.prio;
      slot_ff.id   <= slot_in.id;
      if (reset) begin
         slot_ff.valid    <= 1'b0;
         slot_ff.squashed <= 1'b0;
         flags_ff         <= '0;
      end else begin
         slot_ff.valid    <= slot_in.valid;
         slot_ff.squashed <= slot_in.squashed;
         flags_ff         <= flags_in;
      end
   end

   assign slot_out  = slot_ff;
   assign flags_out = flags_ff;

endmodule

>>> rtl/core/timed_event_priority_queue_core.sv
`timescale 1ns / 1ps
// Top level of the timed event priority queue: control sequencer, status logic and
// the row of tepq_cell slots. Depends on tepq_pkg and tepq_cell.
//
// Usage. Operations arrive on the req_ channel (valid/ready) and each one yields
// exactly one result item on the rsp_ channel (valid/ready). An operation inserts an
// event, removes or squashes an event by id, or pops the head of the queue. Entries
// are kept sorted by due tick and then by signed priority, a new entry going ahead of
// entries with an equal key.
// Steps. Every item passes through the states ST_IDLE, in which it is accepted,
// ST_EVAL, in which every cell compares its entry with the operation and registers
// the result, and ST_APPLY, in which the status is resolved and the whole row shifts
// or updates at once. The result is valid in the cycle after that, and a new item
// is accepted only once the last one has left ST_APPLY.
// Stalls. The result sits in an output register; the next item is accepted while it
// waits, and only the final update stage holds until the output register is free.
// Reset. Reset clears every valid and squashed bit, leaving the queue
// empty; there is no clearing pass. Slot payloads are not reset.
module timed_event_priority_queue_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_func,
   input  logic [7:0]        req_event_id,
   input  logic [63:0]       req_due_tick,
   input  logic signed [7:0] req_prio,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [1:0]        rsp_status,
   output logic              rsp_popped,
   output logic [7:0]        rsp_popped_id,
   output logic [63:0]       rsp_popped_tick,
   output logic signed [7:0] rsp_popped_prio,
   output logic              rsp_run_action,
   output logic              rsp_queue_empty
);

   localparam int Depth = tepq_pkg::QUEUE_DEPTH;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_APPLY
   } state_type;

   state_type           state_ff, state_in;
   tepq_pkg::func_type  func_ff;
   logic [7:0]          id_ff;
   logic [63:0]         tick_ff;
   logic signed [7:0]   prio_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   tepq_pkg::status_type status_ff, status_in;
   logic                popped_ff, popped_in;
   logic [7:0]          popped_id_ff, popped_id_in;
   logic [63:0]         popped_tick_ff, popped_tick_in;
   logic signed [7:0]   popped_prio_ff, popped_prio_in;
   logic                run_action_ff, run_action_in;
   logic                queue_empty_ff, queue_empty_in;

   tepq_pkg::cmd_type   cmd;
   tepq_pkg::slot_type  slots [Depth];
   tepq_pkg::flag_type  flags [Depth];
   logic [Depth-1:0]    match_vec;
   logic [Depth-1:0]    pre_vec;
   logic [Depth-1:0]    valid_vec;
   logic                out_free;
   logic                apply_go;
   logic                any_match;
   logic                queue_full;
   logic                head_valid;
   logic                second_valid;

   always_comb begin
      for (int i = 0; i < Depth; i++) begin
         match_vec[i] = flags[i].match;
         valid_vec[i] = slots[i].valid;
      end
   end

   // Ids in the queue are unique, so at most one cell matches; every cell at or
   // behind the match shifts on a remove.
   assign pre_vec      = tepq_pkg::prefix_or(match_vec);
   assign any_match    = pre_vec[Depth-1];
   assign queue_full   = valid_vec[Depth-1];
   assign head_valid   = valid_vec[0];
   assign second_valid = valid_vec[1];

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign apply_go  = (state_ff == ST_APPLY) && out_free;
   assign req_ready = (state_ff == ST_IDLE);

   // Status of the held operation, from the registered compare flags and the slot valid bits.
   always_comb begin
      case (func_ff)
         tepq_pkg::FUNC_INSERT: begin
            if (any_match) begin
               status_in = tepq_pkg::STATUS_DUPLICATE;
            end else if (queue_full) begin
               status_in = tepq_pkg::STATUS_FULL;
            end else begin
               status_in = tepq_pkg::STATUS_OK;
            end
         end
         tepq_pkg::FUNC_POP: begin
            status_in = head_valid ? tepq_pkg::STATUS_OK : tepq_pkg::STATUS_MISSING;
         end
         default: begin
            status_in = any_match ? tepq_pkg::STATUS_OK : tepq_pkg::STATUS_MISSING;
         end
      endcase
   end

   always_comb begin
      cmd.eval  = (state_ff == ST_EVAL);
      cmd.apply = apply_go;
      cmd.ok    = (status_in == tepq_pkg::STATUS_OK);
      cmd.func  = func_ff;
      cmd.id    = id_ff;
      cmd.tick  = tick_ff;
      cmd.prio  = prio_ff;
   end

   // Result fields; the popped fields are zero unless the head leaves.
   always_comb begin
      popped_in      = 1'b0;
      popped_id_in   = '0;
      popped_tick_in = '0;
      popped_prio_in = '0;
      run_action_in  = 1'b0;
      queue_empty_in = !head_valid;
      if (cmd.ok) begin
         case (func_ff)
            tepq_pkg::FUNC_INSERT: begin
               queue_empty_in = 1'b0;
            end
            tepq_pkg::FUNC_REMOVE: begin
               queue_empty_in = !second_valid;
            end
            tepq_pkg::FUNC_POP: begin
               popped_in      = 1'b1;
               popped_id_in   = slots[0].id;
               popped_tick_in = slots[0].tick;
               popped_prio_in = slots[0].prio;
               run_action_in  = !slots[0].squashed;
               queue_empty_in = !second_valid;
            end
            default: begin
               queue_empty_in = !head_valid;
            end
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            if (out_free) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if ((state_ff == ST_IDLE) && req_valid) begin
         func_ff <= tepq_pkg::func_type'(req_func);
         id_ff   <= req_event_id;
         tick_ff <= req_due_tick;
         prio_ff <= req_prio;
      end
      if (apply_go) begin
         status_ff      <= status_in;
         popped_ff      <= popped_in;
         popped_id_ff   <= popped_id_in;
         popped_tick_ff <= popped_tick_in;
         popped_prio_ff <= popped_prio_in;
         run_action_ff  <= run_action_in;
         queue_empty_ff <= queue_empty_in;
      end
   end

   // The row of cells. The head cell has no left neighbour and the tail cell takes
   // an empty slot from the right.
   for (genvar g = 0; g < Depth; g++) begin : g_cell
      tepq_pkg::slot_type left_slot;
      tepq_pkg::slot_type right_slot;
      logic               left_after;

      if (g == 0) begin : g_head
         assign left_slot  = '0;
         assign left_after = 1'b0;
      end else begin : g_body
         assign left_slot  = slots[g-1];
         assign left_after = flags[g-1].after;
      end

      if (g == Depth - 1) begin : g_tail
         assign right_slot = '0;
      end else begin : g_inner
         assign right_slot = slots[g+1];
      end

      tepq_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .pre_match  (pre_vec[g]),
         .left_after (left_after),
         .left_slot  (left_slot),
         .right_slot (right_slot),
         .slot_out   (slots[g]),
         .flags_out  (flags[g])
      );
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_popped      = popped_ff;
   assign rsp_popped_id   = popped_id_ff;
   assign rsp_popped_tick = popped_tick_ff;
   assign rsp_popped_prio = popped_prio_ff;
   assign rsp_run_action  = run_action_ff;
   assign rsp_queue_empty = queue_empty_ff;

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for timed_event_priority_queue_core: directed and random
// operation streams checked against a shadow copy of the sorted event queue.
// Depends on tepq_pkg and the queue RTL only.
module tb;
   import tepq_pkg::*;

   // The run is cut off after this many nanoseconds.
   localparam int unsigned RUN_LIMIT_NS = 2_000_000;
   // Cycles allowed after the last result for anything stray to appear.
   localparam int TAIL_CYCLES = 12;
   localparam int MAX_REPORTS = 10;
   localparam int IDLE_PERCENT = 34;

   // What one operation is expected to return.
   typedef struct packed {
      status_type        status;
      logic              popped;
      logic [7:0]        id;
      logic [63:0]       tick;
      logic signed [7:0] prio;
      logic              run;
      logic              empty;
   } outcome_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [1:0]        req_func = FUNC_POP;
   logic [7:0]        req_event_id = '0;
   logic [63:0]       req_due_tick = '0;
   logic signed [7:0] req_prio = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [1:0]        rsp_status;
   logic              rsp_popped;
   logic [7:0]        rsp_popped_id;
   logic [63:0]       rsp_popped_tick;
   logic signed [7:0] rsp_popped_prio;
   logic              rsp_run_action;
   logic              rsp_queue_empty;

   // Shadow of the queue contents. Only the first sh_count slots are meaningful,
   // since the valid slots always form a prefix starting at the head.
   logic [63:0]       sh_tick     [QUEUE_DEPTH];
   logic signed [7:0] sh_prio     [QUEUE_DEPTH];
   logic [7:0]        sh_id       [QUEUE_DEPTH];
   logic              sh_squashed [QUEUE_DEPTH];
   int                sh_count = 0;

   outcome_type pending_outcomes[$];
   int          mismatch_count = 0;
   // When clear, neither side of the bench idles nor stalls.
   bit          idle_on = 1'b1;

   timed_event_priority_queue_core dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_event_id    (req_event_id),
      .req_due_tick    (req_due_tick),
      .req_prio        (req_prio),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_popped      (rsp_popped),
      .rsp_popped_id   (rsp_popped_id),
      .rsp_popped_tick (rsp_popped_tick),
      .rsp_popped_prio (rsp_popped_prio),
      .rsp_run_action  (rsp_run_action),
      .rsp_queue_empty (rsp_queue_empty)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Returns the slot holding the given id, or -1 when it is not queued.
   function automatic int find_slot(input logic [7:0] id);
      for (int i = 0; i < sh_count; i++) begin
         if (sh_id[i] == id) return i;
      end
      return -1;
   endfunction

   // Closes the gap left at slot pos by moving every later entry one slot down.
   function automatic void close_gap(input int pos);
      for (int i = pos; i + 1 < sh_count; i++) begin
         sh_tick[i]     = sh_tick[i + 1];
         sh_prio[i]     = sh_prio[i + 1];
         sh_id[i]       = sh_id[i + 1];
         sh_squashed[i] = sh_squashed[i + 1];
      end
      sh_count--;
   endfunction

   // Applies one operation to the shadow queue and returns the result it gives.
   function automatic outcome_type predict_outcome(input func_type func,
                                                   input logic [7:0] id,
                                                   input logic [63:0] tick,
                                                   input logic signed [7:0] prio);
      outcome_type o;
      int          pos;
      int          at;
      o = '0;
      o.status = STATUS_OK;
      pos = find_slot(id);
      case (func)
         FUNC_INSERT: begin
            // The duplicate check takes precedence over the full check.
            if (pos >= 0) begin
               o.status = STATUS_DUPLICATE;
            end else if (sh_count >= QUEUE_DEPTH) begin
               o.status = STATUS_FULL;
            end else begin
               at = 0;
               while (at < sh_count && (sh_tick[at] < tick ||
                      (sh_tick[at] == tick && sh_prio[at] < prio))) begin
                  at++;
               end
               for (int i = sh_count; i > at; i--) begin
                  sh_tick[i]     = sh_tick[i - 1];
                  sh_prio[i]     = sh_prio[i - 1];
                  sh_id[i]       = sh_id[i - 1];
                  sh_squashed[i] = sh_squashed[i - 1];
               end
               sh_tick[at]     = tick;
               sh_prio[at]     = prio;
               sh_id[at]       = id;
               sh_squashed[at] = 1'b0;
               sh_count++;
            end
         end
         FUNC_REMOVE: begin
            if (pos < 0) o.status = STATUS_MISSING;
            else close_gap(pos);
         end
         FUNC_POP: begin
            if (sh_count == 0) begin
               o.status = STATUS_MISSING;
            end else begin
               o.popped = 1'b1;
               o.id     = sh_id[0];
               o.tick   = sh_tick[0];
               o.prio   = sh_prio[0];
               o.run    = !sh_squashed[0];
               close_gap(0);
            end
         end
         default: begin
            if (pos < 0) o.status = STATUS_MISSING;
            else sh_squashed[pos] = 1'b1;
         end
      endcase
      o.empty = (sh_count == 0);
      return o;
   endfunction

   // Presents one item, holding it until the queue takes it, then records what
   // it should return. Called and returning at a rising edge.
   task automatic send_op(input func_type func, input logic [7:0] id,
                          input logic [63:0] tick, input logic signed [7:0] prio);
      outcome_type expected;
      while (idle_on && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_func     <= func;
      req_event_id <= id;
      req_due_tick <= tick;
      req_prio     <= prio;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected = predict_outcome(func, id, tick, prio);
      pending_outcomes.insert(pending_outcomes.size(), expected);
   endtask

   // Stops sending and waits until every outstanding result has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_outcomes.size() != 0);
   endtask

   // Most of the time an id that is queued, so that removes, squashes and
   // duplicate inserts find their target; otherwise any id at all.
   function automatic logic [7:0] pick_id();
      if (sh_count > 0 && $urandom_range(99) < 55) return sh_id[$urandom_range(sh_count - 1)];
      return 8'($urandom);
   endfunction

   // Ticks are drawn so that equal keys are common, with the full range and
   // the values near the top of it well represented.
   function automatic logic [63:0] pick_tick();
      case ($urandom_range(4))
         0:       return 64'($urandom_range(3));
         1:       return 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(3));
         2:       return (sh_count > 0) ? sh_tick[$urandom_range(sh_count - 1)]
                                        : 64'($urandom_range(7));
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic logic signed [7:0] pick_prio();
      case ($urandom_range(3))
         0:       return 8'sd0 - 8'($urandom_range(1));
         1:       return (sh_count > 0) ? sh_prio[$urandom_range(sh_count - 1)] : 8'sh7F;
         default: return 8'($urandom);
      endcase
   endfunction

   // Reset is held from the start of the run and released once.
   task automatic apply_reset();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
   endtask

   // Empty-queue errors, the key extremes, ordering of equal keys, duplicate
   // ids, squashing twice and popping a squashed entry.
   task automatic test_directed();
      send_op(FUNC_POP,    8'd0,   64'd0, 8'sd0);
      send_op(FUNC_REMOVE, 8'd7,   64'd0, 8'sd0);
      send_op(FUNC_SQUASH, 8'd7,   64'd0, 8'sd0);
      send_op(FUNC_INSERT, 8'd255, 64'hFFFF_FFFF_FFFF_FFFF, 8'sh7F);
      send_op(FUNC_INSERT, 8'd0,   64'd0, -8'sd128);
      send_op(FUNC_INSERT, 8'd0,   64'd5, 8'sd3);
      // Same key as id 0, so it must land ahead of it.
      send_op(FUNC_INSERT, 8'd5,   64'd0, -8'sd128);
      send_op(FUNC_INSERT, 8'd9,   64'hFFFF_FFFF_FFFF_FFFF, -8'sd1);
      send_op(FUNC_SQUASH, 8'd255, 64'd0, 8'sd0);
      send_op(FUNC_SQUASH, 8'd255, 64'd0, 8'sd0);
      send_op(FUNC_REMOVE, 8'd0,   64'd0, 8'sd0);
      send_op(FUNC_REMOVE, 8'd0,   64'd0, 8'sd0);
      send_op(FUNC_POP,    8'hAA,  64'h5555_5555_5555_5555, 8'sh55);
      send_op(FUNC_POP,    8'd0,   64'd0, 8'sd0);
      send_op(FUNC_POP,    8'd0,   64'd0, 8'sd0);
      send_op(FUNC_POP,    8'd0,   64'd0, 8'sd0);
   endtask

   // Fills the queue, then checks the full and duplicate cases on a full queue
   // and empties it again, squashed entries among the pops.
   task automatic test_full_queue();
      int n;
      n = 0;
      while (sh_count < QUEUE_DEPTH) begin
         send_op(FUNC_INSERT, 8'(8'd16 + n), pick_tick(), pick_prio());
         n++;
      end
      send_op(FUNC_INSERT, 8'd200, 64'd0, -8'sd128);
      send_op(FUNC_INSERT, sh_id[QUEUE_DEPTH - 1], 64'd0, 8'sd0);
      send_op(FUNC_SQUASH, sh_id[0], 64'd0, 8'sd0);
      send_op(FUNC_SQUASH, sh_id[QUEUE_DEPTH - 1], 64'd0, 8'sd0);
      while (sh_count > 0) send_op(FUNC_POP, 8'($urandom), pick_tick(), pick_prio());
      send_op(FUNC_POP, 8'd0, 64'd0, 8'sd0);
   endtask

   // Random operations. The mix swings between filling and draining every so
   // often, so the queue spends time both empty and full.
   task automatic test_random_traffic(input int count);
      bit          filling;
      int          roll;
      func_type    func;
      filling = 1'b1;
      for (int k = 0; k < count; k++) begin
         if ($urandom_range(79) == 0) filling = !filling;
         roll = $urandom_range(99);
         if (filling) begin
            func = (roll < 60) ? FUNC_INSERT : (roll < 75) ? FUNC_POP :
                   (roll < 85) ? FUNC_REMOVE : FUNC_SQUASH;
         end else begin
            func = (roll < 20) ? FUNC_INSERT : (roll < 65) ? FUNC_POP :
                   (roll < 85) ? FUNC_REMOVE : FUNC_SQUASH;
         end
         send_op(func, pick_id(), pick_tick(), pick_prio());
      end
   endtask

   // A stretch at full rate on both sides, with no gaps and no stalls.
   task automatic test_back_to_back(input int count);
      idle_on = 1'b0;
      test_random_traffic(count);
      idle_on = 1'b1;
   endtask

   // Result checker: takes each returned item, compares it with the oldest
   // expectation and drives the result side's ready, stalling at random.
   always @(posedge clock) begin
      outcome_type want;
      outcome_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {status_type'(rsp_status), rsp_popped, rsp_popped_id, rsp_popped_tick,
                rsp_popped_prio, rsp_run_action, rsp_queue_empty};
         if (pending_outcomes.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("[%0t] unexpected result item: status %0d popped %0b id %0d",
                        $realtime, rsp_status, rsp_popped, rsp_popped_id);
         end else begin
            want = pending_outcomes.pop_front();
            if (got.status !== want.status || got.popped !== want.popped ||
                got.id !== want.id || got.tick !== want.tick ||
                got.prio !== want.prio || got.run !== want.run ||
                got.empty !== want.empty) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS) begin
                  $display("[%0t] result differs: expected status %0d popped %0b id %0d",
                           $realtime, want.status, want.popped, want.id);
                  $display("   tick %0h prio %0d run %0b empty %0b",
                           want.tick, want.prio, want.run, want.empty);
                  $display("   actual status %0d popped %0b id %0d tick %0h",
                           got.status, got.popped, got.id, got.tick);
                  $display("   prio %0d run %0b empty %0b", got.prio, got.run, got.empty);
               end
            end
         end
      end
      rsp_ready <= !(idle_on && $urandom_range(99) < IDLE_PERCENT);
   end

   // Sequence of tests. A pause until all has drained follows every phase but the
   // back-to-back run, and makes the sender wait on the result side at least once.
   initial begin
      apply_reset();
      test_directed();
      drain_results();
      test_full_queue();
      drain_results();
      test_random_traffic(700);
      drain_results();
      test_back_to_back(300);
      test_random_traffic(700);
      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_outcomes.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Watchdog: a hang anywhere ends the run as a failure.
   initial begin
      #(RUN_LIMIT_NS);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

>>> sim.f
rtl/core/tepq_pkg.sv
rtl/core/tepq_cell.sv
rtl/core/timed_event_priority_queue_core.sv
bench/tb.sv
